// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the touch slot mapper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define TSM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tsm assertion failed");

// Condition must never be seen outside reset.
`define TSM_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tsm forbidden condition");

`endif

// ----- rtl/core/tsm_pkg.sv -----
// ----------------------------------------------------------------------------
// tsm_pkg
// Types, codes and constants of the touch slot mapper.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 16;

  // operation / event codes
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_MOVE   = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;
  localparam logic [1:0] OP_CANCEL = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
  localparam logic [1:0] REG_INV_SCALE_X = 2'd2;
  localparam logic [1:0] REG_INV_SCALE_Y = 2'd3;

  localparam logic [15:0] INV_SCALE_RST = 16'd4096;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] touch_id;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic               last_in_batch;
  } in_req_t;

  typedef struct packed {
    logic [3:0]         slot;
    logic [1:0]         event_code;
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic [1:0]         status;
    logic               batch_end;
  } out_res_t;

  // search token walking down the cell chain
  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic        found;
    logic        free;
  } token_t;

  // update broadcast to the cells
  typedef struct packed {
    logic        en;
    logic        set;
    logic [31:0] id;
  } cell_wr_t;

endpackage

// ----- rtl/core/tsm_cell.sv -----
// ----------------------------------------------------------------------------
// tsm_cell
// One slot of the mapper: holds in-use flag and touch ID, checks the
// passing search token and forwards it to the next slot.
// ----------------------------------------------------------------------------
module tsm_cell #(
  parameter int unsigned SLOT_W = 4,
  parameter int unsigned IDX    = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsm_pkg::token_t     tok_i,
  input  logic [SLOT_W-1:0]   fslot_i,
  input  logic [SLOT_W-1:0]   frslot_i,
  output tsm_pkg::token_t     tok_o,
  output logic [SLOT_W-1:0]   fslot_o,
  output logic [SLOT_W-1:0]   frslot_o,
  input  tsm_pkg::cell_wr_t   wr_i,
  input  logic [SLOT_W-1:0]   wr_slot_i
);

  localparam logic [SLOT_W-1:0] MyIdx = SLOT_W'(IDX);

  logic        in_use_q;
  logic [31:0] id_q;
  logic        hit, take_free;

  tsm_pkg::token_t   tok_d, tok_q;
  logic [SLOT_W-1:0] fslot_d, fslot_q, frslot_d, frslot_q;

  // lowest index wins: only record when nothing earlier did
  assign hit       = in_use_q && (id_q == tok_i.id) && !tok_i.found;
  assign take_free = !in_use_q && !tok_i.free;

  always_comb begin
    tok_d       = tok_i;
    fslot_d     = fslot_i;
    frslot_d    = frslot_i;
    if (hit) begin
      tok_d.found = 1'b1;
      fslot_d     = MyIdx;
    end
    if (take_free) begin
      tok_d.free = 1'b1;
      frslot_d   = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= 1'b0;
      tok_q    <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_i.en && (wr_slot_i == MyIdx)) begin
        in_use_q <= wr_i.set;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fslot_q     <= fslot_d;
    frslot_q    <= frslot_d;
    if (wr_i.en && wr_i.set && (wr_slot_i == MyIdx)) begin
      id_q <= wr_i.id;
    end
  end

  assign tok_o    = tok_q;
  assign fslot_o  = fslot_q;
  assign frslot_o = frslot_q;

endmodule

// ----- rtl/core/tsm_conv.sv -----
// ----------------------------------------------------------------------------
// tsm_conv
// Pixel to point conversion: registered multiply by a Q4.12 inverse scale,
// round to Q16.4 (ties up) and saturate to 20 bits.
// ----------------------------------------------------------------------------
module tsm_conv (
  input  logic               clk_i,
  input  logic signed [16:0] delta_i,
  input  logic [15:0]        inv_i,
  output logic signed [19:0] point_o
);

  localparam logic signed [25:0] QMax = 26'sd524287;
  localparam logic signed [25:0] QMin = -26'sd524288;

  logic signed [16:0] inv_s;
  logic signed [33:0] prod_d, prod_q, sum;
  logic signed [25:0] quo;

  assign inv_s  = {1'b0, inv_i};
  assign prod_d = delta_i * inv_s;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // floor((p + 128) / 256)
  assign sum = prod_q + 34'sd128;
  assign quo = sum[33:8];

  always_comb begin
    if (quo > QMax) begin
      point_o = QMax[19:0];
    end else if (quo < QMin) begin
      point_o = QMin[19:0];
    end else begin
      point_o = quo[19:0];
    end
  end

endmodule

// ----- rtl/core/touch_slot_mapper.sv -----
// ----------------------------------------------------------------------------
// touch_slot_mapper
// Maps 32-bit system touch IDs onto dense slot numbers and converts pixel
// positions to points.
// ----------------------------------------------------------------------------
// One request at a time. The slot table is a row of MAX_SLOTS cells; a
// search token enters cell 0 on the accepting edge and steps one cell per
// clock, picking up the matching slot and the lowest free slot. The search
// result is registered as the token leaves the last cell, then loaded into
// the output register once it is free; the next request can be accepted in
// the cycle after the load, so the time per request is set by the length of
// the cell chain. A finished result waits in the output register while the
// next request is accepted and searched; it is held only if a new result is
// ready before the old one is taken. Slot state is cleared by reset with no
// clearing pass. Positions are converted as (pos - origin) * inv_scale with
// Q4.12 scales, rounded to Q16.4 (ties toward +inf) and saturated to 20
// bits. Registers (APB, 4-byte stride): origin_x, origin_y, inv_scale_x,
// inv_scale_y; write them only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module touch_slot_mapper #(
  parameter int unsigned MAX_SLOTS = tsm_pkg::MAX_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tsm_pkg::in_req_t   in_req_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tsm_pkg::out_res_t  out_res_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned SLOT_XW = (SLOT_W > 4) ? SLOT_W : 4;

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic signed [15:0] origin_x_q, origin_y_q;
  logic [15:0]        inv_x_q, inv_y_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      inv_x_q    <= tsm_pkg::INV_SCALE_RST;
      inv_y_q    <= tsm_pkg::INV_SCALE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        tsm_pkg::REG_ORIGIN_X:    origin_x_q <= pwdata[15:0];
        tsm_pkg::REG_ORIGIN_Y:    origin_y_q <= pwdata[15:0];
        tsm_pkg::REG_INV_SCALE_X: inv_x_q    <= pwdata[15:0];
        tsm_pkg::REG_INV_SCALE_Y: inv_y_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tsm_pkg::REG_ORIGIN_X:    prdata = 32'(origin_x_q);
      tsm_pkg::REG_ORIGIN_Y:    prdata = 32'(origin_y_q);
      tsm_pkg::REG_INV_SCALE_X: prdata = {16'd0, inv_x_q};
      tsm_pkg::REG_INV_SCALE_Y: prdata = {16'd0, inv_y_q};
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // request capture
  // --------------------------------------------------------------------------
  logic [1:0]         state_q, state_d;
  logic               in_acc;
  tsm_pkg::in_req_t   req_q;
  logic signed [16:0] dx_q, dy_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // position deltas are exact in 17 bits
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
      dx_q  <= 17'(in_req_i.x_pos) - 17'(origin_x_q);
      dy_q  <= 17'(in_req_i.y_pos) - 17'(origin_y_q);
    end
  end

  logic signed [19:0] pt_x, pt_y;

  tsm_conv u_conv_x (
    .clk_i   (clk_i),
    .delta_i (dx_q),
    .inv_i   (inv_x_q),
    .point_o (pt_x)
  );

  tsm_conv u_conv_y (
    .clk_i   (clk_i),
    .delta_i (dy_q),
    .inv_i   (inv_y_q),
    .point_o (pt_y)
  );

  // --------------------------------------------------------------------------
  // cell chain
  // --------------------------------------------------------------------------
  tsm_pkg::token_t   tok    [MAX_SLOTS+1];
  logic [SLOT_W-1:0] fslot  [MAX_SLOTS+1];
  logic [SLOT_W-1:0] frslot [MAX_SLOTS+1];
  logic [MAX_SLOTS-1:0] tok_vld;
  tsm_pkg::cell_wr_t cell_wr;
  logic [SLOT_W-1:0] wr_slot;

  // token enters cell 0 on the accepting edge
  assign tok[0]    = '{valid: in_acc, id: in_req_i.touch_id, found: 1'b0, free: 1'b0};
  assign fslot[0]  = '0;
  assign frslot[0] = '0;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    tsm_cell #(
      .SLOT_W (SLOT_W),
      .IDX    (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok[i]),
      .fslot_i   (fslot[i]),
      .frslot_i  (frslot[i]),
      .tok_o     (tok[i+1]),
      .fslot_o   (fslot[i+1]),
      .frslot_o  (frslot[i+1]),
      .wr_i      (cell_wr),
      .wr_slot_i (wr_slot)
    );
    assign tok_vld[i] = tok[i+1].valid;
  end

  // --------------------------------------------------------------------------
  // search result and decision
  // --------------------------------------------------------------------------
  logic              found_q, free_q;
  logic [SLOT_W-1:0] fslot_q, frslot_q;

  always_ff @(posedge clk_i) begin
    if ((state_q == S_SRCH) && tok[MAX_SLOTS].valid) begin
      found_q  <= tok[MAX_SLOTS].found;
      free_q   <= tok[MAX_SLOTS].free;
      fslot_q  <= fslot[MAX_SLOTS];
      frslot_q <= frslot[MAX_SLOTS];
    end
  end

  logic               out_valid_q;
  tsm_pkg::out_res_t  res_q, res_d;
  logic               load;
  logic [SLOT_W-1:0]  slot_sel;
  logic [SLOT_XW-1:0] slot_x;
  logic               use_pt;

  // result register is free or being emptied this cycle
  assign load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    slot_sel      = '0;
    use_pt        = 1'b0;
    cell_wr.en    = 1'b0;
    cell_wr.set   = 1'b0;
    cell_wr.id    = req_q.touch_id;
    wr_slot       = fslot_q;
    res_d.status  = tsm_pkg::ST_OK;
    if (req_q.operation == tsm_pkg::OP_BEGIN) begin
      if (found_q) begin
        res_d.status = tsm_pkg::ST_DUP;
        slot_sel     = fslot_q;
      end else if (free_q) begin
        slot_sel     = frslot_q;
        use_pt       = 1'b1;
        cell_wr.en   = load;
        cell_wr.set  = 1'b1;
        wr_slot      = frslot_q;
      end else begin
        res_d.status = tsm_pkg::ST_FULL;
      end
    end else if (!found_q) begin
      res_d.status = tsm_pkg::ST_UNKNOWN;
    end else begin
      slot_sel = fslot_q;
      use_pt   = 1'b1;
      // end and cancel release the slot
      cell_wr.en = load && ((req_q.operation == tsm_pkg::OP_END) ||
                            (req_q.operation == tsm_pkg::OP_CANCEL));
    end
    slot_x           = SLOT_XW'(slot_sel);
    res_d.slot       = slot_x[3:0];
    res_d.event_code = req_q.operation;
    res_d.point_x    = use_pt ? pt_x : '0;
    res_d.point_y    = use_pt ? pt_y : '0;
    res_d.batch_end  = req_q.last_in_batch;
  end

  // --------------------------------------------------------------------------
  // controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_SRCH;
      S_SRCH:  if (tok[MAX_SLOTS].valid) state_d = S_DONE;
      S_DONE:  if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // only one search token in flight
  `TSM_ASSERT(a_one_token, clk_i, rst_ni, $onehot0(tok_vld))
  // no token anywhere while idle
  `TSM_ASSERT(a_idle_empty, clk_i, rst_ni, (state_q == S_IDLE) |-> (tok_vld == '0))
  // slot updates never race a search
  `TSM_NEVER(a_wr_vs_tok, clk_i, rst_ni, cell_wr.en && (tok_vld != '0))
  // a new result only comes from the decision state
  `TSM_ASSERT(a_load_src, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DONE))

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for touch_slot_mapper: a table of directed touches,
// then random touch streams under several viewport settings, each result
// compared to a typed row or an in-bench slot table and point converter.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_SLOTS      = tsm_pkg::MAX_SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 2000; // cycles without any handshake
  localparam int DRAIN_CYCLES   = 40;   // > one request time

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  tsm_pkg::in_req_t   in_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  tsm_pkg::out_res_t  out_res_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  touch_slot_mapper #(
    .MAX_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  tsm_pkg::out_res_t pending_res[$];   // expected results, oldest first
  int       mismatches  = 0;
  int       idle_cycles = 0;
  int       stall_left  = 0;
  bit       idle_on     = 1'b1;

  // Shadow of the slot table and the viewport registers
  logic              slot_busy  [NUM_SLOTS];
  logic [31:0]       slot_owner [NUM_SLOTS];
  logic signed [15:0] org_x = '0;
  logic signed [15:0] org_y = '0;
  logic [15:0]        inv_x = tsm_pkg::INV_SCALE_RST;
  logic [15:0]        inv_y = tsm_pkg::INV_SCALE_RST;

  initial begin
    foreach (slot_busy[i]) begin
      slot_busy[i]  = 1'b0;
      slot_owner[i] = '0;
    end
  end

  // Directed table row: request, plus a hand-written expectation when set
  typedef struct {
    tsm_pkg::in_req_t  req;
    logic              has_exp;
    tsm_pkg::out_res_t exp;
  } dir_row_t;

  dir_row_t dir_tab[$];

  // --------------------------------------------------------------------------
  // Point conversion: (pos - origin) * inv_scale, Q.12 -> Q16.4 with
  // round-half-up (add half LSB, floor via arithmetic shift), then clamp.
  // --------------------------------------------------------------------------
  function automatic logic signed [19:0] to_points(logic signed [15:0] pos,
                                                   logic signed [15:0] org,
                                                   logic [15:0] inv);
    longint d;
    longint v;
    d = longint'(pos) - longint'(org);
    v = (d * longint'(inv) + 128) >>> 8;
    if (v > 524287)  v = 524287;
    if (v < -524288) v = -524288;
    return v[19:0];
  endfunction

  function automatic int find_owner(logic [31:0] id);
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_busy[i] && slot_owner[i] == id) return i;
    return -1;
  endfunction

  // Slot lookup / allocation for one touch; updates the shadow table.
  function automatic tsm_pkg::out_res_t map_touch(tsm_pkg::in_req_t r);
    tsm_pkg::out_res_t res;
    int       hit;
    int       free;
    res            = '0;
    res.event_code = r.operation;
    res.batch_end  = r.last_in_batch;
    hit            = find_owner(r.touch_id);
    free           = -1;
    if (r.operation == tsm_pkg::OP_BEGIN) begin
      if (hit >= 0) begin
        // known ID: ignored, but the existing slot is reported
        res.status = tsm_pkg::ST_DUP;
        res.slot   = hit[3:0];
      end else begin
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
          if (!slot_busy[i]) free = i;
        if (free < 0) begin
          res.status = tsm_pkg::ST_FULL;
        end else begin
          slot_busy[free]  = 1'b1;
          slot_owner[free] = r.touch_id;
          res.slot    = free[3:0];
          res.point_x = to_points(r.x_pos, org_x, inv_x);
          res.point_y = to_points(r.y_pos, org_y, inv_y);
          res.status  = tsm_pkg::ST_OK;
        end
      end
    end else if (hit < 0) begin
      res.status = tsm_pkg::ST_UNKNOWN;
    end else begin
      res.slot    = hit[3:0];
      res.point_x = to_points(r.x_pos, org_x, inv_x);
      res.point_y = to_points(r.y_pos, org_y, inv_y);
      res.status  = tsm_pkg::ST_OK;
      // end and cancel release the slot after reporting it
      if (r.operation == tsm_pkg::OP_END || r.operation == tsm_pkg::OP_CANCEL)
        slot_busy[hit] = 1'b0;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_result(input tsm_pkg::out_res_t got);
    tsm_pkg::out_res_t want;
    if (pending_res.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: %p", got));
      return;
    end
    want = pending_res.pop_front();
    if (got.slot !== want.slot)
      report_mismatch($sformatf("slot got %0d want %0d", got.slot, want.slot));
    if (got.event_code !== want.event_code)
      report_mismatch($sformatf("event_code got %0d want %0d",
                                got.event_code, want.event_code));
    if (got.point_x !== want.point_x)
      report_mismatch($sformatf("point_x got %0d want %0d", got.point_x, want.point_x));
    if (got.point_y !== want.point_y)
      report_mismatch($sformatf("point_y got %0d want %0d", got.point_y, want.point_y));
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.batch_end !== want.batch_end)
      report_mismatch($sformatf("batch_end got %0b want %0b",
                                got.batch_end, want.batch_end));
  endtask

  // --------------------------------------------------------------------------
  // Result side: check on every accepted result, random stall bursts.
  // Signals are sampled at the edge, before any NBA of that step lands.
  // --------------------------------------------------------------------------
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) check_result(out_res_o);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8);
        out_stall_i <= 1'b1;
      end
    end
  end

  // Watchdog: any handshake on either channel restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Sends one touch; on acceptance the expectation is queued. With use_typed
  // the hand-written result is queued, the shadow table still advances.
  task automatic send_touch(input tsm_pkg::in_req_t r, input logic use_typed,
                            input tsm_pkg::out_res_t typed);
    tsm_pkg::out_res_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = map_touch(r);
    if (use_typed) predicted = typed;
    pending_res = {pending_res, predicted};
  endtask

  // APB write: setup, then access until pready; shadow updated after
  task automatic reg_write(input logic [1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};  // upper half must be ignored
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tsm_pkg::REG_ORIGIN_X:    org_x = val;
      tsm_pkg::REG_ORIGIN_Y:    org_y = val;
      tsm_pkg::REG_INV_SCALE_X: inv_x = val;
      tsm_pkg::REG_INV_SCALE_Y: inv_y = val;
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] rand_pos();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random touch: mostly well-formed (begin new IDs, move/end/cancel live
  // ones), some duplicate begins, and a slice of noise with random IDs.
  function automatic tsm_pkg::in_req_t gen_touch(int begin_pct);
    tsm_pkg::in_req_t r;
    int      busy[$];
    int      pick;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_busy[i]) busy = {busy, i};
    pick            = $urandom_range(0, 99);
    r.touch_id      = $urandom;
    r.x_pos         = rand_pos();
    r.y_pos         = rand_pos();
    r.last_in_batch = 1'($urandom_range(0, 1));
    if (pick < 10) begin
      r.operation = 2'($urandom_range(0, 3));
    end else if (busy.size() == 0 || pick < 10 + begin_pct) begin
      r.operation = tsm_pkg::OP_BEGIN;
      if (busy.size() != 0 && $urandom_range(0, 4) == 0)
        r.touch_id = slot_owner[busy[$urandom_range(0, busy.size() - 1)]];
    end else begin
      if ($urandom_range(0, 2) != 0)      r.operation = tsm_pkg::OP_MOVE;
      else if ($urandom_range(0, 1) != 0) r.operation = tsm_pkg::OP_END;
      else                                r.operation = tsm_pkg::OP_CANCEL;
      r.touch_id = slot_owner[busy[$urandom_range(0, busy.size() - 1)]];
    end
    return r;
  endfunction

  // Drop valid, let every pending result come back, reprogram, then stream
  task automatic run_phase(input logic [15:0] ox, input logic [15:0] oy,
                           input logic [15:0] ix, input logic [15:0] iy,
                           input int begin_pct, input int count);
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    reg_write(tsm_pkg::REG_ORIGIN_X, ox);
    reg_write(tsm_pkg::REG_ORIGIN_Y, oy);
    reg_write(tsm_pkg::REG_INV_SCALE_X, ix);
    reg_write(tsm_pkg::REG_INV_SCALE_Y, iy);
    repeat (count) send_touch(gen_touch(begin_pct), 1'b0, '0);
  endtask

  function automatic void add_row(logic [1:0] op, logic [31:0] id,
                                  logic signed [15:0] x, logic signed [15:0] y,
                                  logic last, logic has_exp, logic [3:0] slot,
                                  logic signed [19:0] px, logic signed [19:0] py,
                                  logic [1:0] st);
    dir_row_t row;
    row.req     = '{operation: op, touch_id: id, x_pos: x, y_pos: y,
                    last_in_batch: last};
    row.has_exp = has_exp;
    row.exp     = '{slot: slot, event_code: op, point_x: px, point_y: py,
                    status: st, batch_end: last};
    dir_tab = {dir_tab, row};
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset viewport: origin 0, scale 1.0, so points = 16*pos.
    // Move on an empty table is unknown.
    add_row(tsm_pkg::OP_MOVE,   32'h0000_0005, 16'sd1, 16'sd1, 1'b0,
            1'b1, 4'd0, 20'sd0, 20'sd0, tsm_pkg::ST_UNKNOWN);
    // Begin at both position extremes, most negative ID
    add_row(tsm_pkg::OP_BEGIN,  32'h8000_0000, 16'sh7FFF, 16'sh8000, 1'b1,
            1'b1, 4'd0, 20'sd524272, -20'sd524288, tsm_pkg::ST_OK);
    // Duplicate begin: existing slot, zero points
    add_row(tsm_pkg::OP_BEGIN,  32'h8000_0000, 16'sd7, 16'sd7, 1'b0,
            1'b1, 4'd0, 20'sd0, 20'sd0, tsm_pkg::ST_DUP);
    add_row(tsm_pkg::OP_BEGIN,  32'h7FFF_FFFF, 16'sh8000, 16'sh7FFF, 1'b0,
            1'b1, 4'd1, -20'sd524288, 20'sd524272, tsm_pkg::ST_OK);
    add_row(tsm_pkg::OP_MOVE,   32'h7FFF_FFFF, -16'sd1, 16'sd0, 1'b0,
            1'b1, 4'd1, -20'sd16, 20'sd0, tsm_pkg::ST_OK);
    add_row(tsm_pkg::OP_END,    32'h8000_0000, 16'sd0, 16'sd0, 1'b1,
            1'b1, 4'd0, 20'sd0, 20'sd0, tsm_pkg::ST_OK);
    // ID just ended is gone
    add_row(tsm_pkg::OP_CANCEL, 32'h8000_0000, 16'sd9, 16'sd9, 1'b0,
            1'b1, 4'd0, 20'sd0, 20'sd0, tsm_pkg::ST_UNKNOWN);
    add_row(tsm_pkg::OP_CANCEL, 32'h7FFF_FFFF, 16'sd3, -16'sd3, 1'b1,
            1'b1, 4'd1, 20'sd48, -20'sd48, tsm_pkg::ST_OK);
    // Fill every slot, one ID bit per touch
    for (int k = 0; k < NUM_SLOTS; k++)
      add_row(tsm_pkg::OP_BEGIN, 32'h1 << k, 16'(k * 1000 - 8000),
              16'(8000 - k * 777), 1'(k == NUM_SLOTS - 1), 1'b0, '0, '0, '0,
              tsm_pkg::ST_OK);
    // Table full: reported, nothing allocated
    add_row(tsm_pkg::OP_BEGIN,  32'h0000_0000, 16'sd100, 16'sd100, 1'b1,
            1'b1, 4'd0, 20'sd0, 20'sd0, tsm_pkg::ST_FULL);

    foreach (dir_tab[i]) send_touch(dir_tab[i].req, dir_tab[i].has_exp, dir_tab[i].exp);

    // Random part. Viewports: reset values, both extremes (heavy saturation),
    // zero scale, then random ones. Last phase runs with no idling.
    run_phase(16'h0000, 16'h0000, tsm_pkg::INV_SCALE_RST, tsm_pkg::INV_SCALE_RST,
              40, 100);
    run_phase(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 60, 100);
    run_phase(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 40, 100);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 50, 100);
    run_phase(16'($urandom), 16'($urandom), 16'($urandom_range(0, 8192)),
              16'($urandom_range(0, 8192)), 30, 100);
    idle_on = 1'b0;
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 45, 100);

    // Drain, then give the block time to show any stray result
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
